[hdl/cmap_pkg.sv]
// Shared types and constants for the scalar to RGB colormap unit.
`default_nettype none

package cmap_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned RECIP_BITS      = 32;
  localparam int unsigned Q16_BITS        = 17;
  localparam int unsigned CHAN_BITS       = 8;
  localparam int unsigned MODE_BITS       = 3;
  localparam int unsigned CFG_IDX_BITS    = 2;

  localparam logic [Q16_BITS-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_GREY_LIN = 3'd0,
    MODE_GREY_SQ  = 3'd1,
    MODE_MAP_ONE  = 3'd2,
    MODE_MAP_TWO  = 3'd3,
    MODE_MAP_THR  = 3'd4,
    MODE_MAP_FOUR = 3'd5
  } map_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_RANGE_RECIP = 2'd1,
    REG_MAP_MODE    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [CHAN_BITS-1:0] s_t;
    logic [CHAN_BITS-1:0] s_t2;
    logic [CHAN_BITS-1:0] s_u2;
    logic [Q16_BITS-1:0]  t;
  } shade_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } pixel_t;

endpackage

`default_nettype wire

[hdl/cmap_shade.sv]
// Per-mode channel mixing of the scaled intensities into one RGB pixel.
`default_nettype none

module cmap_shade
  import cmap_pkg::*;
(
  input  shade_in_t shade_i,
  output pixel_t    pixel_o
);

  localparam logic [15:0] RECIP5 = 16'd52429;

  logic [9:0]           b_num;
  logic [25:0]          b_prod;
  logic [CHAN_BITS-1:0] b_fifth;
  logic [24:0]          g_prod;
  logic [CHAN_BITS:0]   rb_sum;
  logic [23:0]          r_prod;
  logic [CHAN_BITS-1:0] r_tenth;

  assign b_num   = {1'b0, shade_i.s_t, 1'b0} + {2'b00, shade_i.s_t} + 10'd4;
  assign b_prod  = b_num * RECIP5;
  assign b_fifth = b_prod[25:18];
  assign g_prod  = shade_i.s_t * shade_i.t;
  assign rb_sum  = {1'b0, shade_i.s_t2} + {1'b0, shade_i.s_u2};
  assign r_prod  = shade_i.s_t2 * RECIP5;
  assign r_tenth = {3'b000, r_prod[23:19]};

  always_comb begin
    pixel_o = '0;
    case (map_mode_e'(shade_i.mode))
      MODE_GREY_LIN: begin
        pixel_o.red   = shade_i.s_t;
        pixel_o.green = shade_i.s_t;
        pixel_o.blue  = shade_i.s_t;
      end
      MODE_GREY_SQ: begin
        pixel_o.red   = shade_i.s_t2;
        pixel_o.green = shade_i.s_t2;
        pixel_o.blue  = shade_i.s_t2;
      end
      MODE_MAP_ONE: begin
        pixel_o.red   = shade_i.s_t;
        pixel_o.green = g_prod[23:16];
        pixel_o.blue  = 8'd255 - b_fifth;
      end
      MODE_MAP_TWO: begin
        pixel_o.red   = shade_i.s_t2;
        pixel_o.green = rb_sum[CHAN_BITS:1];
        pixel_o.blue  = shade_i.s_u2;
      end
      MODE_MAP_THR: begin
        pixel_o.red   = shade_i.s_t2;
        pixel_o.green = shade_i.s_t2;
        pixel_o.blue  = 8'd128;
      end
      MODE_MAP_FOUR: begin
        pixel_o.red   = shade_i.s_t2;
        pixel_o.green = r_tenth;
        pixel_o.blue  = r_tenth;
      end
      default: begin
        pixel_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/scalar_to_rgb_colormap_unit.sv]
// Scalar to RGB false-color map: five stages, one pixel per clock unless stalled.
//
// Takes one signed sample per clock and returns one RGB pixel per clock while
// the output is not stalled. The stages are: offset by range_low, multiply
// by range_reciprocal (one SAMPLE_BITS x 32-bit multiplier), clamp to a Q1.16
// fraction t and square t and 1-t, scale by 255, then mix the channels for the
// selected map. Each stage holds only while its successor is full and stalled,
// so idle slots absorb output stalls. Registers are written through the cfg
// port (always ready) and must only change while no request is in flight.
// Modes 6 and 7 give black.
`default_nettype none

module scalar_to_rgb_colormap_unit
  import cmap_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [RECIP_BITS-1:0]   cfg_data_i,

  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]  sample_i,

  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [CHAN_BITS-1:0]    red_o,
  output      logic [CHAN_BITS-1:0]    green_o,
  output      logic [CHAN_BITS-1:0]    blue_o
);

  localparam int unsigned PROD_BITS = SAMPLE_BITS + RECIP_BITS;

  logic [SAMPLE_BITS-1:0] range_low_q;
  logic [RECIP_BITS-1:0]  range_recip_q;
  logic [MODE_BITS-1:0]   map_mode_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  logic [SAMPLE_BITS:0]   diff;
  logic                   pos1_d;
  logic [SAMPLE_BITS-1:0] d1_q;
  logic                   pos1_q;

  logic [PROD_BITS-1:0]   prod2_q;
  logic                   pos2_q;

  logic [Q16_BITS-1:0]    t3_d;
  logic [Q16_BITS-1:0]    u3_d;
  logic [2*Q16_BITS-1:0]  tt;
  logic [2*Q16_BITS-1:0]  uu;
  logic [Q16_BITS-1:0]    t3_q, t2_3_q, u2_3_q;

  logic [24:0]            sc_t, sc_t2, sc_u2;
  shade_in_t              shade4_q;
  pixel_t                 pixel5_d;
  pixel_t                 pixel5_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q   <= '0;
      range_recip_q <= {{(RECIP_BITS-1){1'b0}}, 1'b1};
      map_mode_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RANGE_LOW:   range_low_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_RANGE_RECIP: range_recip_q <= cfg_data_i;
        REG_MAP_MODE:    map_mode_q    <= cfg_data_i[MODE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign diff = {sample_i[SAMPLE_BITS-1], sample_i}
              - {range_low_q[SAMPLE_BITS-1], range_low_q};
  assign pos1_d = !diff[SAMPLE_BITS] && (diff != '0) && (range_recip_q != '0);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      d1_q   <= diff[SAMPLE_BITS-1:0];
      pos1_q <= pos1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod2_q <= d1_q * range_recip_q;
      pos2_q  <= pos1_q;
    end
  end

  always_comb begin
    if (!pos2_q) begin
      t3_d = '0;
    end else if (prod2_q[PROD_BITS-1:32] != '0) begin
      t3_d = ONE_Q16;
    end else begin
      t3_d = {1'b0, prod2_q[31:16]};
    end
  end

  assign u3_d = ONE_Q16 - t3_d;
  assign tt   = t3_d * t3_d;
  assign uu   = u3_d * u3_d;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      t3_q   <= t3_d;
      t2_3_q <= tt[32:16];
      u2_3_q <= uu[32:16];
    end
  end

  assign sc_t  = {t3_q, 8'h00}   - {8'h00, t3_q};
  assign sc_t2 = {t2_3_q, 8'h00} - {8'h00, t2_3_q};
  assign sc_u2 = {u2_3_q, 8'h00} - {8'h00, u2_3_q};

  always_ff @(posedge clk_i) begin
    if (en4) begin
      shade4_q.mode <= map_mode_q;
      shade4_q.s_t  <= sc_t[23:16];
      shade4_q.s_t2 <= sc_t2[23:16];
      shade4_q.s_u2 <= sc_u2[23:16];
      shade4_q.t    <= t3_q;
    end
  end

  cmap_shade u_shade (
    .shade_i (shade4_q),
    .pixel_o (pixel5_d)
  );

  always_ff @(posedge clk_i) begin
    if (en5) begin
      pixel5_q <= pixel5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign red_o       = pixel5_q.red;
  assign green_o     = pixel5_q.green;
  assign blue_o      = pixel5_q.blue;

endmodule

`default_nettype wire
